### hw/rtl/hmm_vit_pkg.sv
// Package for the HMM Viterbi decoder: mode codes, FSM states, score field width.
// No dependencies; used by hmm_viterbi_decoder_core.
`timescale 1ns / 1ps

package hmm_vit_pkg;

    typedef enum logic [1:0] {
        MODE_TRANS = 2'd0,
        MODE_START = 2'd1,
        MODE_FRAME = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACS,
        ST_COMMIT,
        ST_BEST,
        ST_TRACE,
        ST_EMIT
    } state_t;

    localparam int FIELD_W = 32;

endpackage

### hw/rtl/hmm_vit_lane.sv
// One add-compare-select lane: scans predecessors one per cycle while step is high, for one state.
// Depends on nothing outside its parameters.
`timescale 1ns / 1ps

module hmm_vit_lane #(
    parameter int SW = 32,
    parameter int IW = 3
) (
    input  logic          aclk,
    input  logic          clr,
    input  logic          step,
    input  logic [IW-1:0] pred,
    input  logic [SW-1:0] cand,
    output logic [SW-1:0] best,
    output logic [IW-1:0] best_idx
);

    logic [SW-1:0] best_reg, best_next;
    logic [IW-1:0] idx_reg, idx_next;

    // Keep the strictly larger candidate so the lowest index wins ties.
    always_comb begin
        best_next = best_reg;
        idx_next  = idx_reg;
        if (clr) begin
            best_next = {1'b1, {(SW-1){1'b0}}};
            idx_next  = '0;
        end else if (step && ($signed(cand) > $signed(best_reg))) begin
            best_next = cand;
            idx_next  = pred;
        end
    end

    always_ff @(posedge aclk) begin
        best_reg <= best_next;
        idx_reg  <= idx_next;
    end

    assign best     = best_reg;
    assign best_idx = idx_reg;

endmodule

### hw/rtl/hmm_viterbi_decoder_core.sv
// Top level of the HMM Viterbi decoder: lanes, merge, score store, traceback.
// Depends on hmm_vit_pkg and hmm_vit_lane.
//
// channel   dir  handshake                 contents
// s_axis    in   s_tvalid/s_tready         mode, indexes, last flag, eight scores
// m_axis    out  m_tvalid/m_tready         state, time, path score, last, overflow
// cfg       in   cfg_valid/cfg_ready       num_states
//
// For a frame the lanes scan one predecessor per cycle, then the merge stage
// commits scores and back pointers. A last frame then runs a best-state search
// and gives one result per sample, each through the trace and emit states
// (traceback reads one pointer row per result).
// Reset is synchronous and active low; stalls on m_tready hold the result.
`timescale 1ns / 1ps

module hmm_viterbi_decoder_core #(
    parameter int MAX_STATES  = 8,
    parameter int MAX_SAMPLES = 64,
    parameter int SCORE_WIDTH = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [1:0] mode, [4:2] row_index, [7:5] col_index, [39:8] score_0 ...
    // [263:232] score_7
    input  logic [263:0] s_tdata,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [2:0] state_index, [8:3] time_index, [40:9] path_score, [41] overflow
    output logic [47:0]  m_tdata,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [3:0]   cfg_data
);

    localparam int SW  = SCORE_WIDTH;
    localparam int IW  = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam int TW  = $clog2(MAX_SAMPLES + 1);
    localparam int AW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int FW  = hmm_vit_pkg::FIELD_W;
    localparam int NIN = 8;
    localparam logic [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};

    // Saturating add with minus infinity absorbing.
    function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a, input logic [SW-1:0] b);
        logic signed [SW:0] s;
        begin
            s = {a[SW-1], a} + {b[SW-1], b};
            if (a == SMIN || b == SMIN) sat_add = SMIN;
            else if (s > $signed({1'b0, SMAX})) sat_add = SMAX;
            else if (s < $signed({SMIN[SW-1], SMIN}) + 1) sat_add = SMIN + 1'b1;
            else sat_add = s[SW-1:0];
        end
    endfunction

    // Field to internal score, clamped to the score width.
    function automatic logic [SW-1:0] from_field(input logic [FW-1:0] v);
        logic signed [63:0] x;
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        begin
            x  = 64'($signed(v));
            hi = 64'($signed(SMAX));
            lo = 64'($signed(SMIN)) + 64'sd1;
            if (v == {1'b1, {(FW-1){1'b0}}}) from_field = SMIN;
            else if (x > hi) from_field = SMAX;
            else if (x < lo) from_field = SMIN + 1'b1;
            else from_field = x[SW-1:0];
        end
    endfunction

    function automatic logic [FW-1:0] to_field(input logic [SW-1:0] x);
        logic signed [63:0] v;
        begin
            v = 64'($signed(x));
            if (x == SMIN) to_field = {1'b1, {(FW-1){1'b0}}};
            else if (v > 64'sd2147483647) to_field = 32'h7fffffff;
            else if (v < -64'sd2147483647) to_field = 32'h80000001;
            else to_field = v[FW-1:0];
        end
    endfunction

    // Ring buffer address: base plus offset, wrapped once by compare and subtract.
    function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] b,
                                                input logic [TW-1:0] o);
        logic [TW:0] s;
        begin
            s = (TW+1)'(b) + (TW+1)'(o);
            if (s >= (TW+1)'(MAX_SAMPLES)) s = s - (TW+1)'(MAX_SAMPLES);
            ring_addr = AW'(s);
        end
    endfunction

    // Input word fields.
    logic [1:0] in_mode;
    logic [2:0] in_row, in_col;
    assign in_mode = s_tdata[1:0];
    assign in_row  = s_tdata[4:2];
    assign in_col  = s_tdata[7:5];

    // Stores. Transition scores are kept one row of destinations per entry.
    logic [SW-1:0] start_reg [MAX_STATES];
    logic [MAX_STATES*SW-1:0] trans_reg [MAX_STATES];
    logic [SW-1:0] path_reg  [MAX_STATES];
    logic [SW-1:0] emit_reg  [MAX_STATES];
    logic [IW*MAX_STATES-1:0] bp_mem [MAX_SAMPLES];
    logic [AW-1:0] base_reg, base_next;
    logic [TW-1:0] tcnt_reg, tcnt_next;
    logic          ovf_reg, ovf_next;
    logic          last_reg, last_next;
    logic [3:0]    nst_reg;
    logic [IW:0]   k;

    hmm_vit_pkg::state_t st_reg, st_next;
    logic [IW:0]   cnt_reg, cnt_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic [SW-1:0] bsc_reg, bsc_next;
    logic [TW-1:0] w_reg, w_next;
    logic [IW*MAX_STATES-1:0] row_reg;

    logic accept, frame_go;
    assign s_tready  = (st_reg == hmm_vit_pkg::ST_IDLE) && !m_tvalid;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign frame_go  = accept && (in_mode == hmm_vit_pkg::MODE_FRAME);

    // Active state count.
    always_comb begin
        if (nst_reg == 4'd0) k = (IW+1)'(1);
        else if (32'(nst_reg) > MAX_STATES) k = (IW+1)'(MAX_STATES);
        else k = (IW+1)'(nst_reg);
    end

    // Lanes.
    logic [SW-1:0] lane_best [MAX_STATES];
    logic [IW-1:0] lane_idx  [MAX_STATES];
    logic          lane_clr, lane_step;
    logic [IW-1:0] pred;
    assign lane_clr  = frame_go;
    assign pred      = cnt_reg[IW-1:0];
    assign lane_step = (st_reg == hmm_vit_pkg::ST_ACS) && (cnt_reg < k) && (tcnt_reg != '0);

    for (genvar j = 0; j < MAX_STATES; j++) begin : g_lane
        logic [SW-1:0] cand;
        assign cand = sat_add(path_reg[pred], trans_reg[pred][j*SW +: SW]);
        hmm_vit_lane #(.SW(SW), .IW(IW)) u_lane (
            .aclk(aclk), .clr(lane_clr), .step(lane_step), .pred(pred),
            .cand(cand), .best(lane_best[j]), .best_idx(lane_idx[j])
        );
    end

    // Merge: new path scores and back pointer row.
    logic [SW-1:0] nxt_sc [MAX_STATES];
    logic [IW*MAX_STATES-1:0] nxt_bp;
    always_comb begin
        nxt_bp = '0;
        for (int j = 0; j < MAX_STATES; j++) begin
            nxt_sc[j] = SMIN;
            if (j < 32'(k)) begin
                if (tcnt_reg == '0) nxt_sc[j] = sat_add(start_reg[j], emit_reg[j]);
                else begin
                    nxt_sc[j] = sat_add(lane_best[j], emit_reg[j]);
                    nxt_bp[j*IW +: IW] = lane_idx[j];
                end
            end
        end
    end

    // Next state.
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            hmm_vit_pkg::ST_IDLE:   if (frame_go) st_next = hmm_vit_pkg::ST_ACS;
            hmm_vit_pkg::ST_ACS:    if (cnt_reg == (IW+1)'(MAX_STATES - 1))
                                        st_next = hmm_vit_pkg::ST_COMMIT;
            hmm_vit_pkg::ST_COMMIT: st_next = last_reg ? hmm_vit_pkg::ST_BEST
                                                       : hmm_vit_pkg::ST_IDLE;
            hmm_vit_pkg::ST_BEST:   if (cnt_reg == (IW+1)'(MAX_STATES - 1))
                                        st_next = hmm_vit_pkg::ST_TRACE;
            hmm_vit_pkg::ST_TRACE:  st_next = hmm_vit_pkg::ST_EMIT;
            hmm_vit_pkg::ST_EMIT:   if (m_tvalid && m_tready)
                                        st_next = (w_reg == '0) ? hmm_vit_pkg::ST_IDLE
                                                                : hmm_vit_pkg::ST_TRACE;
            default:                st_next = hmm_vit_pkg::ST_IDLE;
        endcase
    end

    // Datapath control.
    logic [AW-1:0] rd_addr;
    logic          out_load;
    always_comb begin
        cnt_next  = cnt_reg;
        cur_next  = cur_reg;
        bsc_next  = bsc_reg;
        w_next    = w_reg;
        base_next = base_reg;
        tcnt_next = tcnt_reg;
        ovf_next  = ovf_reg;
        last_next = last_reg;
        out_load  = 1'b0;
        rd_addr   = ring_addr(base_reg, w_reg);
        unique case (st_reg)
            hmm_vit_pkg::ST_IDLE: begin
                cnt_next = '0;
                if (frame_go) last_next = s_tlast;
            end
            hmm_vit_pkg::ST_ACS: cnt_next = cnt_reg + 1'b1;
            hmm_vit_pkg::ST_COMMIT: begin
                cnt_next = '0;
                bsc_next = SMIN;
                cur_next = '0;
                if (32'(tcnt_reg) < MAX_SAMPLES) tcnt_next = tcnt_reg + 1'b1;
                else begin
                    ovf_next  = 1'b1;
                    base_next = ring_addr(base_reg, TW'(1));
                end
            end
            hmm_vit_pkg::ST_BEST: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg < k && $signed(path_reg[cnt_reg[IW-1:0]]) > $signed(bsc_reg)) begin
                    bsc_next = path_reg[cnt_reg[IW-1:0]];
                    cur_next = cnt_reg[IW-1:0];
                end
                w_next = tcnt_reg - 1'b1;
            end
            hmm_vit_pkg::ST_TRACE: out_load = 1'b1;
            hmm_vit_pkg::ST_EMIT: begin
                if (m_tvalid && m_tready) begin
                    if (w_reg == '0) begin
                        tcnt_next = '0;
                        ovf_next  = 1'b0;
                        base_next = '0;
                    end else begin
                        cur_next = row_reg[cur_reg*IW +: IW];
                        w_next   = w_reg - 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= hmm_vit_pkg::ST_IDLE;
            cnt_reg  <= '0;
            tcnt_reg <= '0;
            ovf_reg  <= 1'b0;
            base_reg <= '0;
            last_reg <= 1'b0;
            nst_reg  <= 4'd8;
            m_tvalid <= 1'b0;
        end else begin
            st_reg   <= st_next;
            cnt_reg  <= cnt_next;
            tcnt_reg <= tcnt_next;
            ovf_reg  <= ovf_next;
            base_reg <= base_next;
            last_reg <= last_next;
            if (cfg_valid && cfg_ready) nst_reg <= cfg_data;
            if (out_load) m_tvalid <= 1'b1;
            else if (m_tready) m_tvalid <= 1'b0;
        end
    end

    // Path scores reset to zero; committed each frame.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < MAX_STATES; j++) path_reg[j] <= '0;
        end else if (st_reg == hmm_vit_pkg::ST_COMMIT) begin
            for (int j = 0; j < MAX_STATES; j++) path_reg[j] <= nxt_sc[j];
        end
    end

    // Score loads, emission capture, payload registers.
    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        bsc_reg <= bsc_next;
        w_reg   <= w_next;
        if (accept && in_mode == hmm_vit_pkg::MODE_TRANS && 32'(in_row) < MAX_STATES
                && 32'(in_col) < MAX_STATES)
            trans_reg[IW'(in_row)][32'(in_col)*SW +: SW] <= from_field(s_tdata[8 +: FW]);
        if (accept && in_mode == hmm_vit_pkg::MODE_START && 32'(in_row) < MAX_STATES)
            start_reg[IW'(in_row)] <= from_field(s_tdata[8 +: FW]);
        if (frame_go) begin
            for (int j = 0; j < MAX_STATES; j++)
                emit_reg[j] <= (j < NIN) ? from_field(s_tdata[8 + FW*(j % NIN) +: FW]) : SMIN;
        end
        if (out_load) begin
            m_tdata <= {6'd0, ovf_reg, to_field(bsc_reg), 6'(w_reg), 3'(cur_reg)};
            m_tlast <= (w_reg == '0);
        end
    end

    // Back pointer memory: circular buffer, one row per sample.
    always_ff @(posedge aclk) begin
        if (st_reg == hmm_vit_pkg::ST_COMMIT)
            bp_mem[ring_addr(base_reg, tcnt_reg)] <= nxt_bp;
        row_reg <= bp_mem[rd_addr];
    end

`ifndef SYNTH
    ap_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> st_reg == hmm_vit_pkg::ST_IDLE) else $error("ready outside idle");
    ap_tcnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(tcnt_reg) <= MAX_SAMPLES) else $error("sample count overran");
    ap_out_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> st_reg == hmm_vit_pkg::ST_EMIT) else $error("result outside emit");
`endif

endmodule
